### hw/rtl/scfq_pkg.sv
package scfq_pkg;

    // Store and flow sizing
    localparam int QUEUE_DEPTH = 16;
    localparam int NUM_FLOWS   = 3;
    localparam int NUM_REGS    = 3;
    localparam int OCC_W       = $clog2(QUEUE_DEPTH + 1);

    // Field widths
    localparam int TAG_W  = 48;
    localparam int FLOW_W = 2;
    localparam int LEN_W  = 16;
    localparam int DIV_W  = 8;
    localparam int PROD_W = LEN_W + DIV_W;
    localparam int CFG_W  = 2;
    localparam int STAT_W = 2;

    // Request kinds
    localparam logic REQ_ARRIVE  = 1'b0;
    localparam logic REQ_DEQUEUE = 1'b1;

    // Result status codes
    localparam logic [STAT_W-1:0] STAT_ENQUEUED = 2'd0;
    localparam logic [STAT_W-1:0] STAT_DEQUEUED = 2'd1;
    localparam logic [STAT_W-1:0] STAT_DROPPED  = 2'd2;
    localparam logic [STAT_W-1:0] STAT_EMPTY    = 2'd3;

    // One stored packet
    typedef struct packed {
        logic [TAG_W-1:0]  tag;
        logic [FLOW_W-1:0] flow;
        logic [LEN_W-1:0]  len;
    } t_entry;

    // Commands broadcast to every cell
    typedef struct packed {
        logic insert;
        logic remove;
    } t_cell_ctl;

endpackage

### hw/rtl/scfq_cell.sv
module scfq_cell (
    input  logic               i_clk,
    input  scfq_pkg::t_cell_ctl i_ctl,
    input  scfq_pkg::t_entry   i_new,
    input  logic               i_occupied,
    input  scfq_pkg::t_entry   i_left,
    input  logic               i_left_take,
    input  scfq_pkg::t_entry   i_right,
    output scfq_pkg::t_entry   o_entry,
    output logic               o_take
);

    scfq_pkg::t_entry r_entry;

    // New item belongs at or before this cell: empty, or strictly larger tag
    assign o_take  = !i_occupied || (r_entry.tag > i_new.tag);
    assign o_entry = r_entry;

    // Shift right on insert past the slot, shift left on remove
    always_ff @(posedge i_clk) begin
        if (i_ctl.insert) begin
            if (o_take) begin
                if (i_left_take) begin
                    r_entry <= i_left;
                end else begin
                    r_entry <= i_new;
                end
            end
        end else if (i_ctl.remove) begin
            r_entry <= i_right;
        end
    end

endmodule

### hw/rtl/scfq_packet_scheduler.sv
// Channel  | Direction | Handshake          | Payload
// request  | in        | i_valid / o_ready  | i_req_type, i_flow_id, i_packet_length
// result   | out       | o_valid / i_ready  | o_status, o_out_flow, o_out_length, o_finish_tag
// config   | in        | i_cfg_we           | i_cfg_idx, i_cfg_data
//
// A dequeue reads the head cell; an arrival runs tag base and multiply, saturating
// add, broadcast insert into the cell chain. A new request waits for the last result.
// The store is a sorted chain of cells; the head cell always holds the smallest tag,
// equal tags kept in arrival order.
// Reset clears occupancy, virtual time, flow tags and sets every divisor to 1; no
// clearing pass runs. A result waiting in the output register stalls only the final
// step of the next item.
module scfq_packet_scheduler (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic                                i_req_type,
    input  logic [scfq_pkg::FLOW_W-1:0]         i_flow_id,
    input  logic [scfq_pkg::LEN_W-1:0]          i_packet_length,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [scfq_pkg::STAT_W-1:0]         o_status,
    output logic [scfq_pkg::FLOW_W-1:0]         o_out_flow,
    output logic [scfq_pkg::LEN_W-1:0]          o_out_length,
    output logic [scfq_pkg::TAG_W-1:0]          o_finish_tag,
    input  logic                                i_cfg_we,
    input  logic [scfq_pkg::CFG_W-1:0]          i_cfg_idx,
    input  logic [scfq_pkg::DIV_W-1:0]          i_cfg_data
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_CALC = 3'd1;
    localparam logic [2:0] ST_ADD  = 3'd2;
    localparam logic [2:0] ST_INS  = 3'd3;
    localparam logic [2:0] ST_DEQ  = 3'd4;

    localparam int TAG_W  = scfq_pkg::TAG_W;
    localparam int PROD_W = scfq_pkg::PROD_W;
    localparam int DEPTH  = scfq_pkg::QUEUE_DEPTH;
    localparam int OCC_W  = scfq_pkg::OCC_W;

    logic [2:0]                       r_state, n_state;
    logic                             r_req;
    logic [scfq_pkg::FLOW_W-1:0]      r_flow;
    logic [scfq_pkg::LEN_W-1:0]       r_len;
    logic [TAG_W-1:0]                 r_base;
    logic [PROD_W-1:0]                r_inc;
    logic [TAG_W-1:0]                 r_tag;
    logic [OCC_W-1:0]                 r_occ;
    logic [TAG_W-1:0]                 r_vc;
    logic [TAG_W-1:0]                 r_last [scfq_pkg::NUM_FLOWS];
    logic [scfq_pkg::DIV_W-1:0]       r_div  [scfq_pkg::NUM_FLOWS];
    logic                             r_out_valid;
    logic [scfq_pkg::STAT_W-1:0]      r_status;
    logic [scfq_pkg::FLOW_W-1:0]      r_out_flow;
    logic [scfq_pkg::LEN_W-1:0]       r_out_len;
    logic [TAG_W-1:0]                 r_out_tag;

    logic                             w_in_fire;
    logic                             w_out_free;
    logic                             w_flow_ok;
    logic                             w_full;
    logic                             w_load;
    logic [TAG_W-1:0]                 w_vc_now;
    logic [TAG_W-1:0]                 w_last;
    logic [TAG_W:0]                   w_sum;
    scfq_pkg::t_cell_ctl              w_ctl;
    scfq_pkg::t_entry                 w_new;
    scfq_pkg::t_entry                 w_entry [DEPTH];
    logic                             w_take  [DEPTH];

    assign w_in_fire  = i_valid && o_ready;
    assign w_out_free = !r_out_valid || i_ready;
    assign w_flow_ok  = (32'(r_flow) < scfq_pkg::NUM_FLOWS);
    assign w_full     = (r_occ == OCC_W'(DEPTH));
    assign w_vc_now   = (r_occ != '0) ? w_entry[0].tag : r_vc;
    assign w_last     = r_last[r_flow];
    assign w_sum      = {1'b0, r_base} + {{(TAG_W + 1 - PROD_W){1'b0}}, r_inc};

    // A result enters the output register in the final step of an item
    assign w_load = w_out_free &&
                    (((r_state == ST_CALC) && (!w_flow_ok || w_full)) ||
                     (r_state == ST_INS) || (r_state == ST_DEQ));

    assign o_ready      = (r_state == ST_IDLE);
    assign o_valid      = r_out_valid;
    assign o_status     = r_status;
    assign o_out_flow   = r_out_flow;
    assign o_out_length = r_out_len;
    assign o_finish_tag = r_out_tag;

    // Broadcast commands and the new entry to the chain
    assign w_ctl.insert = (r_state == ST_INS) && w_out_free;
    assign w_ctl.remove = (r_state == ST_DEQ) && w_out_free && (r_occ != '0);
    assign w_new.tag    = r_tag;
    assign w_new.flow   = r_flow;
    assign w_new.len    = r_len;

    // Chain of sorted cells, head at index 0
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        scfq_pkg::t_entry w_left;
        scfq_pkg::t_entry w_right;
        logic             w_left_take;

        if (g == 0) begin : g_head
            assign w_left      = '0;
            assign w_left_take = 1'b0;
        end else begin : g_mid
            assign w_left      = w_entry[g-1];
            assign w_left_take = w_take[g-1];
        end

        if (g == DEPTH - 1) begin : g_tail
            assign w_right = '0;
        end else begin : g_body
            assign w_right = w_entry[g+1];
        end

        scfq_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl),
            .i_new       (w_new),
            .i_occupied  (OCC_W'(g) < r_occ),
            .i_left      (w_left),
            .i_left_take (w_left_take),
            .i_right     (w_right),
            .o_entry     (w_entry[g]),
            .o_take      (w_take[g])
        );
    end

    // Sequence one item at a time
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_fire) begin
                    n_state = (i_req_type == scfq_pkg::REQ_DEQUEUE) ? ST_DEQ : ST_CALC;
                end
            end
            ST_CALC: begin
                if (!w_flow_ok || w_full) begin
                    if (w_out_free) begin
                        n_state = ST_IDLE;
                    end
                end else begin
                    n_state = ST_ADD;
                end
            end
            ST_ADD: begin
                n_state = ST_INS;
            end
            ST_INS, ST_DEQ: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control state, flow tags, virtual time and divisors
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_occ       <= '0;
            r_vc        <= '0;
            r_out_valid <= 1'b0;
            for (int f = 0; f < scfq_pkg::NUM_FLOWS; f++) begin
                r_last[f] <= '0;
                r_div[f]  <= scfq_pkg::DIV_W'(1);
            end
        end else begin
            r_state <= n_state;

            if (i_cfg_we && (32'(i_cfg_idx) < scfq_pkg::NUM_REGS)) begin
                r_div[i_cfg_idx] <= i_cfg_data;
            end

            // Hold a waiting result, drop it once taken, raise it on a load
            r_out_valid <= w_load || (r_out_valid && !i_ready);

            if (r_state == ST_CALC && w_flow_ok) begin
                r_vc <= w_vc_now;
            end

            if (w_ctl.insert) begin
                r_occ          <= r_occ + OCC_W'(1);
                r_last[r_flow] <= r_tag;
            end

            if (w_ctl.remove) begin
                r_occ <= r_occ - OCC_W'(1);
            end
        end
    end

    // Capture the item, then base, increment and saturated tag
    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_req  <= i_req_type;
            r_flow <= i_flow_id;
            r_len  <= i_packet_length;
        end
        if (r_state == ST_CALC) begin
            r_base <= (w_vc_now > w_last) ? w_vc_now : w_last;
            r_inc  <= PROD_W'(r_len) * PROD_W'(r_div[r_flow]);
        end
        if (r_state == ST_ADD) begin
            r_tag <= w_sum[TAG_W] ? {TAG_W{1'b1}} : w_sum[TAG_W-1:0];
        end
    end

    // Load the result register
    always_ff @(posedge i_clk) begin
        if (w_out_free) begin
            if (r_state == ST_CALC && (!w_flow_ok || w_full)) begin
                r_status   <= scfq_pkg::STAT_DROPPED;
                r_out_flow <= r_flow;
                r_out_len  <= '0;
                r_out_tag  <= '0;
            end else if (r_state == ST_INS) begin
                r_status   <= scfq_pkg::STAT_ENQUEUED;
                r_out_flow <= r_flow;
                r_out_len  <= '0;
                r_out_tag  <= r_tag;
            end else if (r_state == ST_DEQ && r_req == scfq_pkg::REQ_DEQUEUE) begin
                if (r_occ == '0) begin
                    r_status   <= scfq_pkg::STAT_EMPTY;
                    r_out_flow <= '0;
                    r_out_len  <= '0;
                    r_out_tag  <= '0;
                end else begin
                    r_status   <= scfq_pkg::STAT_DEQUEUED;
                    r_out_flow <= w_entry[0].flow;
                    r_out_len  <= w_entry[0].len;
                    r_out_tag  <= w_entry[0].tag;
                end
            end
        end
    end

    // Occupancy stays within the chain
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= OCC_W'(DEPTH))
        else $error("occupancy exceeds queue depth");

    // Head of the chain holds a tag no larger than the next cell's
    a_head_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_occ >= OCC_W'(2)) |-> (w_entry[0].tag <= w_entry[1].tag))
        else $error("cell chain out of order at head");

    // A removal drops occupancy by exactly one
    a_remove_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.remove |=> (r_occ == $past(r_occ) - OCC_W'(1)))
        else $error("occupancy not reduced after removal");

    // An insert never happens into a full chain
    a_insert_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.insert |-> (r_occ < OCC_W'(DEPTH)))
        else $error("insert into full chain");

endmodule

### sim/scfq_packet_scheduler_test.sv
module scfq_packet_scheduler_test;
    import scfq_pkg::*;

    // Register indexes of the configuration port
    localparam logic [CFG_W-1:0] REG_FLOW0_DIV = 2'd0;
    localparam logic [CFG_W-1:0] REG_FLOW1_DIV = 2'd1;
    localparam logic [CFG_W-1:0] REG_FLOW2_DIV = 2'd2;
    localparam logic [CFG_W-1:0] REG_UNUSED    = 2'd3;

    // Flow code outside the configured flows
    localparam logic [FLOW_W-1:0] FLOW_BAD = 2'd3;

    localparam int ITEMS_PER_PHASE = 205;
    localparam int NUM_PHASES      = 5;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int ARRIVE_LATENCY  = 4;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [FLOW_W-1:0] flow;
        logic [LEN_W-1:0]  len;
        logic [TAG_W-1:0]  tag;
    } t_result;

    // Tracks the fair queue state and the results it owes, oldest first
    class fair_queue_tracker;
        bit [TAG_W-1:0]  tags[QUEUE_DEPTH];
        bit [FLOW_W-1:0] flows[QUEUE_DEPTH];
        bit [LEN_W-1:0]  lens[QUEUE_DEPTH];
        bit [31:0]       order[QUEUE_DEPTH];
        int unsigned     occ;
        bit [TAG_W-1:0]  vclock;
        bit [TAG_W-1:0]  flow_tag[NUM_FLOWS];
        bit [31:0]       arrivals;
        bit [DIV_W-1:0]  divisor[NUM_FLOWS];
        t_result         due_results[$];
        int              errors;

        function new();
            occ = 0;
            vclock = '0;
            arrivals = '0;
            errors = 0;
            for (int f = 0; f < NUM_FLOWS; f++) begin
                flow_tag[f] = '0;
                divisor[f] = 1;
            end
        endfunction

        function void set_divisor(logic [CFG_W-1:0] idx, logic [DIV_W-1:0] value);
            if (idx < NUM_FLOWS) divisor[idx] = value;
        endfunction

        function int pending();
            return due_results.size();
        endfunction

        // Slot of the smallest tag; the older arrival wins a tie
        function int unsigned earliest_slot();
            int unsigned best;
            bit [31:0] age_i;
            bit [31:0] age_b;
            best = 0;
            for (int unsigned i = 1; i < occ; i++) begin
                age_i = arrivals - order[i];
                age_b = arrivals - order[best];
                if (tags[i] < tags[best] || (tags[i] == tags[best] && age_i > age_b))
                    best = i;
            end
            return best;
        endfunction

        // Advance the queue state for one accepted request and owe its result
        function void note_request(logic req, logic [FLOW_W-1:0] flow,
                                   logic [LEN_W-1:0] len);
            t_result r;
            bit [TAG_W:0] base;
            bit [TAG_W:0] inc;
            bit [TAG_W:0] sum;
            bit [TAG_W-1:0] tag;
            int unsigned k;
            r = '0;
            if (req == REQ_ARRIVE) begin
                r.flow = flow;
                if (flow >= NUM_FLOWS) begin
                    r.status = STAT_DROPPED;
                end else begin
                    if (occ > 0) vclock = tags[earliest_slot()];
                    if (occ >= QUEUE_DEPTH) begin
                        r.status = STAT_DROPPED;
                    end else begin
                        base = (vclock > flow_tag[flow]) ? vclock : flow_tag[flow];
                        inc = len * divisor[flow];
                        sum = base + inc;
                        tag = sum[TAG_W] ? '1 : sum[TAG_W-1:0];
                        tags[occ] = tag;
                        flows[occ] = flow;
                        lens[occ] = len;
                        order[occ] = arrivals;
                        occ++;
                        arrivals++;
                        flow_tag[flow] = tag;
                        r.status = STAT_ENQUEUED;
                        r.tag = tag;
                    end
                end
            end else if (occ == 0) begin
                r.status = STAT_EMPTY;
            end else begin
                k = earliest_slot();
                r.status = STAT_DEQUEUED;
                r.flow = flows[k];
                r.len = lens[k];
                r.tag = tags[k];
                // Move the last entry into the freed slot
                tags[k] = tags[occ-1];
                flows[k] = flows[occ-1];
                lens[k] = lens[occ-1];
                order[k] = order[occ-1];
                occ--;
            end
            due_results.push_back(r);
        endfunction

        // Compare one delivered result with the oldest owed one
        function void check_result(t_result got);
            t_result want;
            if (due_results.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: status %0d flow %0d len %0d tag %0h",
                             got.status, got.flow, got.len, got.tag);
                return;
            end
            want = due_results.pop_front();
            if (got.status !== want.status || got.flow !== want.flow ||
                got.len !== want.len || got.tag !== want.tag) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: want status %0d flow %0d len %0d tag %0h, got status %0d flow %0d len %0d tag %0h",
                             want.status, want.flow, want.len, want.tag,
                             got.status, got.flow, got.len, got.tag);
            end
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_ready;
    logic              i_req_type;
    logic [FLOW_W-1:0] i_flow_id;
    logic [LEN_W-1:0]  i_packet_length;
    logic              o_valid;
    logic              i_ready;
    logic [STAT_W-1:0] o_status;
    logic [FLOW_W-1:0] o_out_flow;
    logic [LEN_W-1:0]  o_out_length;
    logic [TAG_W-1:0]  o_finish_tag;
    logic              i_cfg_we;
    logic [CFG_W-1:0]  i_cfg_idx;
    logic [DIV_W-1:0]  i_cfg_data;

    fair_queue_tracker queue_model = new();
    bit tx_idle_on;
    bit rx_idle_on;
    int cycle_count;

    scfq_packet_scheduler i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_req_type      (i_req_type),
        .i_flow_id       (i_flow_id),
        .i_packet_length (i_packet_length),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_status        (o_status),
        .o_out_flow      (o_out_flow),
        .o_out_length    (o_out_length),
        .o_finish_tag    (o_finish_tag),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // End the run if it stalls
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("status: fail");
        $finish;
    end

    // Take results and stall in random bursts
    initial begin : result_sink
        int stall_left;
        t_result got;
        stall_left = 0;
        i_ready <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready) begin
                got = {o_status, o_out_flow, o_out_length, o_finish_tag};
                queue_model.check_result(got);
            end
            if (stall_left != 0) begin
                stall_left--;
                if (stall_left == 0) i_ready <= 1'b1;
            end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 8);
                i_ready <= 1'b0;
            end
        end
    end

    // Offer one item, with an optional idle burst first, and hold until accepted
    task automatic send_item(logic req, logic [FLOW_W-1:0] flow, logic [LEN_W-1:0] len);
        if (tx_idle_on && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_req_type <= req;
        i_flow_id <= flow;
        i_packet_length <= len;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        queue_model.note_request(req, flow, len);
    endtask

    // Hold off the sender until every owed result has arrived
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (queue_model.pending() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_W-1:0] idx, logic [DIV_W-1:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        queue_model.set_divisor(idx, value);
    endtask

    // Write all divisors while the block is idle
    task automatic set_divisors(logic [DIV_W-1:0] d0, logic [DIV_W-1:0] d1,
                                logic [DIV_W-1:0] d2);
        drain();
        repeat (ARRIVE_LATENCY) @(posedge i_clk);
        write_reg(REG_FLOW0_DIV, d0);
        write_reg(REG_FLOW1_DIV, d1);
        write_reg(REG_FLOW2_DIV, d2);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [LEN_W-1:0] pick_length();
        case ($urandom_range(0, 9))
            0:       return '1;
            1:       return LEN_W'($urandom_range(0, 3));
            default: return LEN_W'($urandom);
        endcase
    endfunction

    initial begin : stimulus
        int phase;
        int arrive_pct;
        logic [FLOW_W-1:0] flow;
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        i_valid <= 1'b0;
        i_req_type <= REQ_ARRIVE;
        i_flow_id <= '0;
        i_packet_length <= '0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= REG_FLOW0_DIV;
        i_cfg_data <= '0;
        i_rst_n <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Extreme divisors, a zero divisor for equal tags, and the unused index
        write_reg(REG_UNUSED, 8'hA5);
        set_divisors(8'd255, 8'd1, 8'd0);

        // Directed: empty dequeue, bad flow, length extremes, fill to full, drops
        send_item(REQ_DEQUEUE, 2'd0, 16'd0);
        send_item(REQ_ARRIVE, FLOW_BAD, 16'hFFFF);
        send_item(REQ_ARRIVE, 2'd0, 16'hFFFF);
        send_item(REQ_ARRIVE, 2'd1, 16'd0);
        send_item(REQ_ARRIVE, 2'd2, 16'hFFFF);
        send_item(REQ_ARRIVE, 2'd2, 16'd1);
        send_item(REQ_ARRIVE, 2'd1, 16'd1);
        for (int i = 0; i < 11; i++)
            send_item(REQ_ARRIVE, FLOW_W'(i % NUM_FLOWS), (i % 2) ? 16'hAAAA : 16'h5555);
        send_item(REQ_ARRIVE, 2'd0, 16'd7);
        send_item(REQ_ARRIVE, FLOW_BAD, 16'd7);
        send_item(REQ_DEQUEUE, FLOW_BAD, 16'hFFFF);
        repeat (4) send_item(REQ_DEQUEUE, 2'd0, 16'd0);

        // Random phases, each under its own divisor setting
        for (phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                0: set_divisors(8'd1, 8'd1, 8'd1);
                1: set_divisors(8'd255, 8'd255, 8'd255);
                2: set_divisors(8'd0, 8'd255, 8'd1);
                3: set_divisors(DIV_W'($urandom_range(1, 255)),
                                DIV_W'($urandom_range(1, 255)),
                                DIV_W'($urandom_range(1, 255)));
                default: set_divisors(8'd3, 8'd7, 8'd200);
            endcase
            arrive_pct = 50;
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                // Swing between filling and emptying, idling in stretches
                if (n % 32 == 0) begin
                    arrive_pct = $urandom_range(20, 85);
                    tx_idle_on = (phase != NUM_PHASES - 1) && $urandom_range(0, 2) != 0;
                    rx_idle_on = (phase != NUM_PHASES - 1) && $urandom_range(0, 2) != 0;
                end
                if (phase == 1 && n == ITEMS_PER_PHASE / 2) drain();
                flow = ($urandom_range(0, 19) == 0) ? FLOW_BAD
                                                    : FLOW_W'($urandom_range(0, NUM_FLOWS - 1));
                if ($urandom_range(1, 100) <= arrive_pct)
                    send_item(REQ_ARRIVE, flow, pick_length());
                else
                    send_item(REQ_DEQUEUE, FLOW_W'($urandom), LEN_W'($urandom));
            end
        end

        // Wait out the remaining results
        i_valid <= 1'b0;
        while (queue_model.pending() != 0) @(posedge i_clk);
        repeat (2 * ARRIVE_LATENCY) @(posedge i_clk);
        if (queue_model.errors == 0 && queue_model.pending() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
